>>> hw/rtl/top_k_score_tracker_top_defines.svh
// ----------------------------------------------------------------------------
// Top-K score tracker assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TOP_K_SCORE_TRACKER_TOP_DEFINES_SVH
`define TOP_K_SCORE_TRACKER_TOP_DEFINES_SVH

// same-cycle implication
`define TKST_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tkst: same-cycle check failed");

// next-cycle implication
`define TKST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tkst: next-cycle check failed");

`endif

>>> hw/rtl/tkst_pkg.sv
// ----------------------------------------------------------------------------
// Top-K score tracker package
// Field widths, command codes, cell types and the ranking compare.
// ----------------------------------------------------------------------------
package tkst_pkg;

  localparam int SCORE_W = 31;
  localparam int KEY_W   = 24;
  localparam int RANK_W  = 4;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DUMP   = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [SCORE_W-1:0] score;
    logic [KEY_W-1:0]   key;
  } tkst_entry_t;

  // per-cycle command to every cell of the row
  typedef struct packed {
    logic ins;  // insert the offered pair
    logic rot;  // rotate the row one place toward cell 0
  } tkst_ctrl_t;

  // true when pair a ranks strictly ahead of pair b
  function automatic logic ranks_better(input logic [SCORE_W-1:0] score_a,
                                        input logic [KEY_W-1:0]   key_a,
                                        input logic [SCORE_W-1:0] score_b,
                                        input logic [KEY_W-1:0]   key_b);
    return (score_a > score_b) || ((score_a == score_b) && (key_a < key_b));
  endfunction

endpackage

>>> hw/rtl/tkst_cell.sv
// ----------------------------------------------------------------------------
// Top-K score tracker cell
// Holds one ranked entry; takes the offered pair, its upper neighbor's entry
// on a shift, or its lower neighbor's entry on a rotate.
// ----------------------------------------------------------------------------
module tkst_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tkst_pkg::tkst_ctrl_t         ctrl,
  input  logic [tkst_pkg::SCORE_W-1:0] new_score,
  input  logic [tkst_pkg::KEY_W-1:0]   new_key,
  input  tkst_pkg::tkst_entry_t        prev_entry,
  input  logic                         prev_beaten,
  input  tkst_pkg::tkst_entry_t        next_entry,
  output tkst_pkg::tkst_entry_t        entry,
  output logic                         beaten
);

  tkst_pkg::tkst_entry_t entry_r;
  tkst_pkg::tkst_entry_t entry_nxt;

  // an empty cell is always beaten
  assign beaten = !entry_r.valid ||
                  tkst_pkg::ranks_better(new_score, new_key, entry_r.score, entry_r.key);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.rot) begin
      entry_nxt = next_entry;
    end else if (ctrl.ins && beaten) begin
      if (prev_beaten) begin
        entry_nxt = prev_entry;
      end else begin
        entry_nxt.valid = 1'b1;
        entry_nxt.score = new_score;
        entry_nxt.key   = new_key;
      end
    end
  end

  // only the valid bit is reset; score and key follow it
  always_ff @(posedge clk) begin
    entry_r.score <= entry_nxt.score;
    entry_r.key   <= entry_nxt.key;
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
  end

  assign entry = entry_r;

endmodule

>>> hw/rtl/tkst_chain.sv
// ----------------------------------------------------------------------------
// Top-K score tracker cell row
// K cells in rank order, plus the rank encoder for the insert result.
// ----------------------------------------------------------------------------
module tkst_chain #(
  parameter int K_ENTRIES = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tkst_pkg::tkst_ctrl_t         ctrl,
  input  logic [tkst_pkg::SCORE_W-1:0] new_score,
  input  logic [tkst_pkg::KEY_W-1:0]   new_key,
  output tkst_pkg::tkst_entry_t        head_entry,
  output logic                         accepted,
  output logic [tkst_pkg::RANK_W-1:0]  rank
);

  tkst_pkg::tkst_entry_t             entries [K_ENTRIES];
  logic [K_ENTRIES-1:0]              beaten;
  logic [K_ENTRIES-1:0]              take;
  logic [tkst_pkg::RANK_W-1:0]       rank_part [K_ENTRIES];

  genvar gi;
  generate
    for (gi = 0; gi < K_ENTRIES; gi++) begin : g_cell
      tkst_pkg::tkst_entry_t prev_e;
      tkst_pkg::tkst_entry_t next_e;
      logic                  prev_b;

      if (gi == 0) begin : g_head
        assign prev_e = '0;
        assign prev_b = 1'b0;
      end else begin : g_body
        assign prev_e = entries[gi-1];
        assign prev_b = beaten[gi-1];
      end

      // the tail wraps to the head so a full rotate restores the row
      assign next_e = entries[(gi + 1) % K_ENTRIES];

      tkst_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .new_score   (new_score),
        .new_key     (new_key),
        .prev_entry  (prev_e),
        .prev_beaten (prev_b),
        .next_entry  (next_e),
        .entry       (entries[gi]),
        .beaten      (beaten[gi])
      );

      // beaten cells form a suffix, so at most one cell takes a new pair
      assign take[gi]      = beaten[gi] && !prev_b;
      assign rank_part[gi] = take[gi] ? tkst_pkg::RANK_W'(gi) : '0;
    end
  endgenerate

  always_comb begin
    rank = '0;
    for (int i = 0; i < K_ENTRIES; i++) begin
      rank = rank | rank_part[i];
    end
  end

  assign accepted   = |take;
  assign head_entry = entries[0];

endmodule

>>> hw/rtl/top_k_score_tracker_top.sv
// ----------------------------------------------------------------------------
// Top-K score tracker
// Keeps the best K score/key pairs in a row of compare-and-shift cells and
// reports insert results and full-list dumps on a result stream.
// ----------------------------------------------------------------------------
//
//   channel | dir | tdata                                  | tuser / tlast
//   --------+-----+----------------------------------------+----------------------
//   in_     | in  | new_score[30:0] new_key[54:31] 0[55]   | tuser: command
//   out_    | out | rank[3:0] entry_score[34:4]            | tuser: accepted[0],
//           |     | entry_key[58:35] 0[63:59]              | entry_valid[1]; tlast
//
// On an insert request every cell compares the offered pair against its
// own entry at once and the row shifts in the same edge, so inserts
// stream at one per cycle while the result register drains.
// A dump request is accepted, then the row rotates toward cell 0 and
// loads its K_ENTRIES results one per cycle; no new request is taken
// until the last dump result is loaded. Output stalls hold the row.
// Reset empties the list at once (valid bits only); it needs no clear pass.
// ----------------------------------------------------------------------------
module top_k_score_tracker_top #(
  parameter int K_ENTRIES = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // new_score[30:0], new_key[54:31], zero pad
  input  logic [0:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // rank[3:0], entry_score[34:4], entry_key[58:35]
  output logic [1:0]  out_tuser,  // accepted[0], entry_valid[1]
  output logic        out_tlast
);

  localparam int CNT_W = (K_ENTRIES > 1) ? $clog2(K_ENTRIES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(K_ENTRIES - 1);

  // unpack the request
  logic [tkst_pkg::SCORE_W-1:0] new_score;
  logic [tkst_pkg::KEY_W-1:0]   new_key;
  logic                         command;

  assign new_score = in_tdata[tkst_pkg::SCORE_W-1:0];
  assign new_key   = in_tdata[tkst_pkg::SCORE_W +: tkst_pkg::KEY_W];
  assign command   = in_tuser[0];

  // dump sequencer
  logic             dump_act_r, dump_act_nxt;
  logic [CNT_W-1:0] dump_cnt_r, dump_cnt_nxt;

  // result register
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_acc_r, out_acc_nxt;
  logic [tkst_pkg::RANK_W-1:0]  out_rank_r, out_rank_nxt;
  logic                         out_ev_r, out_ev_nxt;
  logic [tkst_pkg::SCORE_W-1:0] out_score_r, out_score_nxt;
  logic [tkst_pkg::KEY_W-1:0]   out_key_r, out_key_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         out_free;
  logic                         in_fire;
  logic                         ins_fire;
  logic                         dump_fire;
  logic                         dump_step;
  logic                         dump_end;
  tkst_pkg::tkst_ctrl_t         ctrl;
  tkst_pkg::tkst_entry_t        head_entry;
  logic                         chain_acc;
  logic [tkst_pkg::RANK_W-1:0]  chain_rank;
  logic [CNT_W+tkst_pkg::RANK_W-1:0] cnt_ext;

  // the result slot can take a new value when empty or being drained
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !dump_act_r && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign ins_fire  = in_fire && (command == tkst_pkg::CMD_INSERT);
  assign dump_fire = in_fire && (command == tkst_pkg::CMD_DUMP);
  assign dump_step = dump_act_r && out_free;
  assign dump_end  = dump_step && (dump_cnt_r == CNT_LAST);

  assign ctrl.ins = ins_fire;
  assign ctrl.rot = dump_step;

  tkst_chain #(
    .K_ENTRIES (K_ENTRIES)
  ) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .new_score  (new_score),
    .new_key    (new_key),
    .head_entry (head_entry),
    .accepted   (chain_acc),
    .rank       (chain_rank)
  );

  // dump position, masked to the rank field width
  assign cnt_ext = {{tkst_pkg::RANK_W{1'b0}}, dump_cnt_r};

  always_comb begin
    dump_act_nxt = dump_act_r;
    dump_cnt_nxt = dump_cnt_r;
    if (dump_fire) begin
      dump_act_nxt = 1'b1;
      dump_cnt_nxt = '0;
    end else if (dump_step) begin
      dump_cnt_nxt = dump_cnt_r + 1'b1;
      if (dump_end) begin
        dump_act_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_acc_nxt   = out_acc_r;
    out_rank_nxt  = out_rank_r;
    out_ev_nxt    = out_ev_r;
    out_score_nxt = out_score_r;
    out_key_nxt   = out_key_r;
    out_last_nxt  = out_last_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (ins_fire) begin
      // a dropped pair reports rank zero
      out_valid_nxt = 1'b1;
      out_acc_nxt   = chain_acc;
      out_rank_nxt  = chain_rank;
      out_ev_nxt    = 1'b0;
      out_score_nxt = '0;
      out_key_nxt   = '0;
      out_last_nxt  = 1'b1;
    end else if (dump_step) begin
      // empty positions read as zero
      out_valid_nxt = 1'b1;
      out_acc_nxt   = 1'b0;
      out_rank_nxt  = cnt_ext[tkst_pkg::RANK_W-1:0];
      out_ev_nxt    = head_entry.valid;
      out_score_nxt = head_entry.valid ? head_entry.score : '0;
      out_key_nxt   = head_entry.valid ? head_entry.key : '0;
      out_last_nxt  = dump_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dump_act_r  <= 1'b0;
      dump_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      dump_act_r  <= dump_act_nxt;
      dump_cnt_r  <= dump_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_acc_r   <= out_acc_nxt;
    out_rank_r  <= out_rank_nxt;
    out_ev_r    <= out_ev_nxt;
    out_score_r <= out_score_nxt;
    out_key_r   <= out_key_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_key_r, out_score_r, out_rank_r};
  assign out_tuser  = {out_ev_r, out_acc_r};
  assign out_tlast  = out_last_r;

endmodule

>>> hw/rtl/tkst_checker.sv
// ----------------------------------------------------------------------------
// Top-K score tracker port checker
// Watches the top level's ports for result ordering and stall behavior.
// ----------------------------------------------------------------------------
`include "top_k_score_tracker_top_defines.svh"

module tkst_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  logic in_fire;
  logic out_stall;
  logic ins_fire;
  logic dump_fire;

  assign in_fire   = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign ins_fire  = in_fire && (in_tuser[0] == tkst_pkg::CMD_INSERT);
  assign dump_fire = in_fire && (in_tuser[0] == tkst_pkg::CMD_DUMP);

  // a request is never taken while a result sits stalled
  `TKST_ASSERT_SAME(a_no_take_on_stall, in_tready, !out_stall)

  // an insert shows its single result on the next cycle
  `TKST_ASSERT_NEXT(a_insert_result, ins_fire, out_tvalid && out_tlast && !out_tuser[1])

  // a dump blocks new requests while its results go out
  `TKST_ASSERT_NEXT(a_dump_blocks, dump_fire, !in_tready)

  // an accepted insert never carries a dumped entry
  `TKST_ASSERT_SAME(a_acc_not_entry, out_tvalid && out_tuser[0], !out_tuser[1] && out_tlast)

  // a stalled result holds
  `TKST_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

endmodule

bind top_k_score_tracker_top tkst_checker u_tkst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> tb/tb_top_k_score_tracker_top.sv
// ----------------------------------------------------------------------------
// Top-K score tracker testbench
// Streams insert and dump requests into the tracker with bursty input timing
// and patterned output stalls. A scoreboard keeps its own ranked list, works
// out every expected insert and dump result, and checks each returned result
// field by field in order.
// ----------------------------------------------------------------------------
module tb_top_k_score_tracker_top;

  localparam int K_ENTRIES    = 10;
  localparam int N_RANDOM     = 110;
  localparam int CYCLE_LIMIT  = 100000;
  // leave slack after the last dump result, scaled to K_ENTRIES
  localparam int DRAIN_CYCLES = 3 * K_ENTRIES;

  localparam logic [tkst_pkg::SCORE_W-1:0] SCORE_MAX = {tkst_pkg::SCORE_W{1'b1}};
  localparam logic [tkst_pkg::KEY_W-1:0]   KEY_MAX   = {tkst_pkg::KEY_W{1'b1}};

  typedef struct packed {
    logic                         accepted;
    logic [tkst_pkg::RANK_W-1:0]  rank;
    logic                         entry_valid;
    logic [tkst_pkg::SCORE_W-1:0] score;
    logic [tkst_pkg::KEY_W-1:0]   key;
    logic                         last;
  } tk_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: ranked list kept alongside the block, plus the queue of
  // results it still owes.
  // --------------------------------------------------------------------------
  class top_k_scoreboard;
    logic [tkst_pkg::SCORE_W-1:0] held_score [K_ENTRIES];
    logic [tkst_pkg::KEY_W-1:0]   held_key   [K_ENTRIES];
    int                           held_count;
    tk_result_t                   expected_q [$];
    int                           errors;
    int                           n_checked;

    function new();
      held_count = 0;
      errors     = 0;
      n_checked  = 0;
    endfunction

    // pair a goes strictly ahead of pair b: higher score, or same score and
    // lower key
    function bit outranks(logic [tkst_pkg::SCORE_W-1:0] score_a,
                          logic [tkst_pkg::KEY_W-1:0]   key_a,
                          logic [tkst_pkg::SCORE_W-1:0] score_b,
                          logic [tkst_pkg::KEY_W-1:0]   key_b);
      return (score_a > score_b) || ((score_a == score_b) && (key_a < key_b));
    endfunction

    // Work out the results of one accepted request and update the list.
    function void note_request(logic cmd, logic [tkst_pkg::SCORE_W-1:0] score,
                               logic [tkst_pkg::KEY_W-1:0] key);
      tk_result_t r;
      int         pos;
      if (cmd == tkst_pkg::CMD_DUMP) begin
        for (int i = 0; i < K_ENTRIES; i++) begin
          r             = '0;
          r.rank        = tkst_pkg::RANK_W'(i);
          r.entry_valid = (i < held_count);
          r.score       = r.entry_valid ? held_score[i] : '0;
          r.key         = r.entry_valid ? held_key[i] : '0;
          r.last        = (i == K_ENTRIES - 1);
          expected_q.push_back(r);
        end
        return;
      end
      r      = '0;
      r.last = 1'b1;
      if (held_count < K_ENTRIES) begin
        pos = held_count;
        held_count++;
      end else if (outranks(score, key, held_score[K_ENTRIES-1],
                            held_key[K_ENTRIES-1])) begin
        pos = K_ENTRIES - 1;
      end else begin
        // full and not better than the tail: drop, rank reads 0
        expected_q.push_back(r);
        return;
      end
      // slide beaten entries down; an equal pair stays behind its twin
      while (pos > 0 && outranks(score, key, held_score[pos-1], held_key[pos-1])) begin
        held_score[pos] = held_score[pos-1];
        held_key[pos]   = held_key[pos-1];
        pos--;
      end
      held_score[pos] = score;
      held_key[pos]   = key;
      r.accepted      = 1'b1;
      r.rank          = tkst_pkg::RANK_W'(pos);
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] result %0d: %s", $time, n_checked, msg);
      errors++;
    endtask

    task check_result(tk_result_t got);
      tk_result_t want;
      if (expected_q.size() == 0) begin
        report("result with nothing expected");
        n_checked++;
        return;
      end
      want = expected_q.pop_front();
      if (got.accepted !== want.accepted)
        report($sformatf("accepted got %0b want %0b", got.accepted, want.accepted));
      if (got.rank !== want.rank)
        report($sformatf("rank got %0d want %0d", got.rank, want.rank));
      if (got.entry_valid !== want.entry_valid)
        report($sformatf("entry_valid got %0b want %0b", got.entry_valid,
                         want.entry_valid));
      if (got.score !== want.score)
        report($sformatf("entry_score got 0x%0h want 0x%0h", got.score, want.score));
      if (got.key !== want.key)
        report($sformatf("entry_key got 0x%0h want 0x%0h", got.key, want.key));
      if (got.last !== want.last)
        report($sformatf("last got %0b want %0b", got.last, want.last));
      n_checked++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block under test
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;    // new_score[30:0], new_key[54:31], zero pad
  logic [0:0]  in_tuser;    // command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;   // rank[3:0], entry_score[34:4], entry_key[58:35]
  logic [1:0]  out_tuser;   // accepted[0], entry_valid[1]
  logic        out_tlast;

  top_k_scoreboard sb;
  int unsigned     cycles = 0;

  always #4 clk = ~clk;

  top_k_score_tracker_top #(
    .K_ENTRIES(K_ENTRIES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // Hard stop: far beyond the slowest legal run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top_k_score_tracker_top failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: sample on the rising edge, stall on a changing pattern.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    tk_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.accepted    = out_tuser[0];
      got.entry_valid = out_tuser[1];
      got.rank        = out_tdata[3:0];
      got.score       = out_tdata[34:4];
      got.key         = out_tdata[58:35];
      got.last        = out_tlast;
      sb.check_result(got);
    end
  end

  // Pick a stall mode and hold it for a stretch: always ready, light random
  // stalls, a repeating 8-bit pattern, or heavy random stalls.
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned stall_step = 0;
  logic [7:0]  stall_pattern = 8'b1011_0110;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode    <= $urandom_range(0, 3);
      stall_left    <= $urandom_range(40, 250);
      stall_pattern <= 8'($urandom) | 8'h01;
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_step <= stall_step + 1;
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= stall_pattern[stall_step % 8];
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Present one request and hold it until the handshake, then note it.
  task send_request(logic cmd, logic [tkst_pkg::SCORE_W-1:0] score,
                    logic [tkst_pkg::KEY_W-1:0] key);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, key, score};
    do @(posedge clk); while (!in_tready);
    sb.note_request(cmd, score, key);
  endtask

  // Drop valid and put noise on the data lines.
  task idle_input(int n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tuser  <= 1'($urandom);
      in_tdata  <= {24'($urandom), 32'($urandom)};
    end
  endtask

  // Hold off until every owed result has come back.
  task wait_for_drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic                         cmd;
    logic [tkst_pkg::SCORE_W-1:0] score;
    logic [tkst_pkg::KEY_W-1:0]   key;
    int                           pick;
    int                           burst_left;

    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = '0;
    in_tdata  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty dump, field extremes, equal pairs, fill to full,
    // drop on a tie with the tail, replace the tail on a key tie-break.
    send_request(tkst_pkg::CMD_DUMP,   SCORE_MAX, KEY_MAX);
    send_request(tkst_pkg::CMD_INSERT, '0, '0);
    send_request(tkst_pkg::CMD_INSERT, SCORE_MAX, KEY_MAX);
    send_request(tkst_pkg::CMD_INSERT, SCORE_MAX, '0);
    send_request(tkst_pkg::CMD_INSERT, SCORE_MAX, KEY_MAX);
    send_request(tkst_pkg::CMD_INSERT, '0, KEY_MAX);
    send_request(tkst_pkg::CMD_INSERT, '0, '0);
    send_request(tkst_pkg::CMD_INSERT, 31'd500, 24'd5);
    send_request(tkst_pkg::CMD_INSERT, 31'd500, 24'd3);
    send_request(tkst_pkg::CMD_INSERT, 31'd1000, 24'd1);
    send_request(tkst_pkg::CMD_INSERT, 31'd7, 24'd7);
    send_request(tkst_pkg::CMD_DUMP,   '0, '0);
    send_request(tkst_pkg::CMD_INSERT, '0, KEY_MAX);
    send_request(tkst_pkg::CMD_INSERT, '0, KEY_MAX - 24'd1);
    send_request(tkst_pkg::CMD_INSERT, '0, '0);
    send_request(tkst_pkg::CMD_INSERT, SCORE_MAX, '0);
    send_request(tkst_pkg::CMD_INSERT, 31'd1, '0);
    send_request(tkst_pkg::CMD_INSERT, 31'h2AAA_AAAA, 24'h55_5555);
    send_request(tkst_pkg::CMD_INSERT, 31'h5555_5555, 24'hAA_AAAA);
    send_request(tkst_pkg::CMD_DUMP,   '0, '0);

    // Random: mostly inserts biased toward ties and the top of the range,
    // with a dump now and then. Bursts of requests with random gaps, one
    // stretch with no gaps and one full drain half way through.
    burst_left = $urandom_range(1, 12);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2)
        wait_for_drain();
      cmd  = ($urandom_range(0, 9) == 0) ? tkst_pkg::CMD_DUMP : tkst_pkg::CMD_INSERT;
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: score = tkst_pkg::SCORE_W'($urandom_range(0, 15));
        3, 4, 5: score = tkst_pkg::SCORE_W'($urandom);
        6:       score = SCORE_MAX;
        default: score = SCORE_MAX - tkst_pkg::SCORE_W'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 3))
        0, 1:    key = tkst_pkg::KEY_W'($urandom_range(0, 7));
        2:       key = tkst_pkg::KEY_W'($urandom);
        default: key = KEY_MAX - tkst_pkg::KEY_W'($urandom_range(0, 3));
      endcase
      // offer a copy (or a near copy) of a held entry to hit equal pairs
      if (pick == 9 && sb.held_count > 0) begin
        pick  = $urandom_range(0, sb.held_count - 1);
        score = sb.held_score[pick];
        key   = sb.held_key[pick] + tkst_pkg::KEY_W'($urandom_range(0, 1));
      end
      send_request(cmd, score, key);
      burst_left--;
      if (burst_left <= 0) begin
        if (n < 20 || n >= 45)
          idle_input($urandom_range(1, 6));
        burst_left = $urandom_range(1, 12);
      end
    end

    // Drain, give the block time to settle, then decide.
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_top_k_score_tracker_top passed");
    end else begin
      $display("tb_top_k_score_tracker_top failed");
    end
    $finish;
  end

endmodule
